// ===== rtl/minv_pkg.sv =====
// Shared constants and types for the 3x3 matrix inverse pipeline.
// Depends on nothing; imported by the pipeline modules and the top level.
package minv_pkg;

   localparam int unsigned NUM_ENTRIES  = 9;
   localparam int unsigned NUM_PRODUCTS = 18;
   localparam int unsigned ROW_TERMS    = 3;

   // Operand indexes of the pairwise products; cofactor i is
   // product 2i minus product 2i+1 (row-major entry indexes).
   localparam int unsigned PROD_A [NUM_PRODUCTS] =
      '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int unsigned PROD_B [NUM_PRODUCTS] =
      '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

   typedef struct packed {
      logic singular;
      logic saturated;
   } minv_status_type;

endpackage

// ===== rtl/minv_if.sv =====
// Valid/ready channel interfaces for the matrix and the inverse transfers.
// Depends on nothing.
interface minv_req_if #(parameter int unsigned ENTRY_WIDTH = 24);
   logic valid;
   logic ready;
   logic signed [ENTRY_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

interface minv_rsp_if #(parameter int unsigned ENTRY_WIDTH = 24);
   logic valid;
   logic ready;
   logic signed [ENTRY_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
   logic singular;
   logic saturated;
   modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, saturated, input ready);
   modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                   singular, saturated, output ready);
endinterface

// ===== rtl/minv_front.sv =====
// Front pipeline: cofactor products, adjugate and exact determinant.
// Depends on minv_pkg.
module minv_front #(
   parameter int unsigned ENTRY_WIDTH = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [ENTRY_WIDTH-1:0] a [minv_pkg::NUM_ENTRIES],
   output logic out_valid,
   input  logic out_ready,
   output logic signed [2*ENTRY_WIDTH:0] adj [minv_pkg::NUM_ENTRIES],
   output logic signed [3*ENTRY_WIDTH+2:0] det
);
   import minv_pkg::*;

   localparam int unsigned EW  = ENTRY_WIDTH;
   localparam int unsigned PW  = 2 * EW;
   localparam int unsigned AW  = PW + 1;
   localparam int unsigned HW  = AW - EW;
   localparam int unsigned PPW = EW + HW;
   localparam int unsigned DW  = 3 * EW + 3;
   localparam int unsigned NS  = 4;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_prev;
   logic [NS-1:0] adv;

   logic signed [PW-1:0]  prod_ff   [NUM_PRODUCTS];
   logic signed [EW-1:0]  row1_ff   [ROW_TERMS];
   logic signed [AW-1:0]  adj2_ff   [NUM_ENTRIES];
   logic signed [EW-1:0]  row2_ff   [ROW_TERMS];
   logic signed [PPW-1:0] pph_ff    [ROW_TERMS];
   logic signed [PPW-1:0] ppl_ff    [ROW_TERMS];
   logic signed [AW-1:0]  adj3_ff   [NUM_ENTRIES];
   logic signed [AW-1:0]  adj4_ff   [NUM_ENTRIES];
   logic signed [DW-1:0]  det_ff;
   logic signed [DW-1:0]  det_in;

   // A stage moves when it is empty or the stage after it moves.
   assign adv[NS-1] = !valid_ff[NS-1] || out_ready;
   for (genvar k = 0; k < NS - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign valid_prev = {valid_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_prev[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int p = 0; p < NUM_PRODUCTS; p++) begin
            prod_ff[p] <= a[PROD_A[p]] * a[PROD_B[p]];
         end
         for (int k = 0; k < ROW_TERMS; k++) begin
            row1_ff[k] <= a[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            adj2_ff[i] <= $signed({prod_ff[2*i][PW-1], prod_ff[2*i]})
                        - $signed({prod_ff[2*i+1][PW-1], prod_ff[2*i+1]});
         end
         row2_ff <= row1_ff;
      end
   end

   // The row-0 expansion splits each cofactor into a signed high part and
   // an unsigned low part so that each multiplier stays near entry width.
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int k = 0; k < ROW_TERMS; k++) begin
            pph_ff[k] <= row2_ff[k] * $signed(adj2_ff[3*k][AW-1:EW]);
            ppl_ff[k] <= row2_ff[k] * $signed({1'b0, adj2_ff[3*k][EW-1:0]});
         end
         adj3_ff <= adj2_ff;
      end
   end

   always_comb begin
      det_in = '0;
      for (int k = 0; k < ROW_TERMS; k++) begin
         det_in = det_in + DW'($signed({pph_ff[k], {EW{1'b0}}})) + DW'(ppl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         det_ff  <= det_in;
         adj4_ff <= adj3_ff;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NS-1];
   assign adj       = adj4_ff;
   assign det       = det_ff;

endmodule

// ===== rtl/minv_div.sv =====
// Pipelined restoring divider for nine quotients against one determinant,
// one quotient bit per stage, with truncation and saturation. Depends on minv_pkg.
module minv_div #(
   parameter int unsigned ENTRY_WIDTH = 24,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [2*ENTRY_WIDTH:0] adj [minv_pkg::NUM_ENTRIES],
   input  logic signed [3*ENTRY_WIDTH+2:0] det,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [ENTRY_WIDTH-1:0] res [minv_pkg::NUM_ENTRIES],
   output minv_pkg::minv_status_type status
);
   import minv_pkg::*;

   localparam int unsigned EW = ENTRY_WIDTH;
   localparam int unsigned AW = 2 * EW + 1;
   localparam int unsigned DW = 3 * EW + 3;
   localparam int unsigned QW = EW + 1;
   localparam int unsigned MW = AW + 2 * FRAC_BITS;
   localparam int unsigned CW = (MW > DW + QW) ? MW : DW + QW;
   localparam int unsigned DS = QW + 2;
   localparam int unsigned NS = DS + 1;
   localparam int unsigned LS = DS - 1;
   localparam logic [QW-1:0] HALF = QW'(1) << (EW - 1);

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_prev;
   logic [NS-1:0] adv;

   logic [CW-1:0] rem_ff  [DS][NUM_ENTRIES];
   logic [QW-1:0] quo_ff  [DS][NUM_ENTRIES];
   logic          neg_ff  [DS][NUM_ENTRIES];
   logic          ovf_ff  [DS][NUM_ENTRIES];
   logic [DW-1:0] den_ff  [DS];
   logic          sing_ff [DS];

   logic [CW-1:0] rem_in [NUM_ENTRIES];
   logic          neg_in [NUM_ENTRIES];
   logic [DW-1:0] den_in;

   logic signed [EW-1:0] res_ff [NUM_ENTRIES];
   logic signed [EW-1:0] res_in [NUM_ENTRIES];
   minv_status_type      status_ff;
   minv_status_type      status_in;

   assign adv[NS-1] = !valid_ff[NS-1] || out_ready;
   for (genvar k = 0; k < NS - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign valid_prev = {valid_ff[NS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_prev[k];
            end
         end
      end
   end

   // Setup: magnitudes, scaled numerators and quotient signs.
   always_comb begin
      logic [AW-1:0] mag;
      den_in = det[DW-1] ? DW'(-det) : DW'(det);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         mag       = adj[i][AW-1] ? AW'(-adj[i]) : AW'(adj[i]);
         rem_in[i] = CW'({mag, {(2*FRAC_BITS){1'b0}}});
         neg_in[i] = adj[i][AW-1] ^ det[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            rem_ff[0][i] <= rem_in[i];
            quo_ff[0][i] <= '0;
            neg_ff[0][i] <= neg_in[i];
            ovf_ff[0][i] <= 1'b0;
         end
         den_ff[0]  <= den_in;
         sing_ff[0] <= (det == '0);
      end
   end

   // A quotient that needs more than QW bits is flagged and clipped later.
   logic [CW-1:0] top_lim;
   assign top_lim = CW'(den_ff[0]) << QW;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            rem_ff[1][i] <= rem_ff[0][i];
            quo_ff[1][i] <= quo_ff[0][i];
            neg_ff[1][i] <= neg_ff[0][i];
            ovf_ff[1][i] <= (rem_ff[0][i] >= top_lim);
         end
         den_ff[1]  <= den_ff[0];
         sing_ff[1] <= sing_ff[0];
      end
   end

   for (genvar s = 2; s < DS; s++) begin : g_step
      localparam int unsigned B = DS - 1 - s;
      logic [CW-1:0] dsh;
      assign dsh = CW'(den_ff[s-1]) << B;

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (rem_ff[s-1][i] >= dsh) begin
                  rem_ff[s][i] <= rem_ff[s-1][i] - dsh;
                  quo_ff[s][i] <= quo_ff[s-1][i] | (QW'(1) << B);
               end else begin
                  rem_ff[s][i] <= rem_ff[s-1][i];
                  quo_ff[s][i] <= quo_ff[s-1][i];
               end
               neg_ff[s][i] <= neg_ff[s-1][i];
               ovf_ff[s][i] <= ovf_ff[s-1][i];
            end
            den_ff[s]  <= den_ff[s-1];
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // Sign, saturation and the zero result of a singular matrix.
   always_comb begin
      logic [QW-1:0] lim;
      logic [QW-1:0] mag;
      logic [QW-1:0] sval;
      logic          clip;
      logic          any_clip;
      any_clip = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         lim       = neg_ff[LS][i] ? HALF : HALF - QW'(1);
         clip      = ovf_ff[LS][i] || (quo_ff[LS][i] > lim);
         mag       = clip ? lim : quo_ff[LS][i];
         sval      = neg_ff[LS][i] ? QW'(0) - mag : mag;
         res_in[i] = sing_ff[LS] ? '0 : $signed(sval[EW-1:0]);
         any_clip  = any_clip | clip;
      end
      status_in.singular  = sing_ff[LS];
      status_in.saturated = any_clip && !sing_ff[LS];
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         res_ff    <= res_in;
         status_ff <= status_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[NS-1];
   assign res       = res_ff;
   assign status    = status_ff;

endmodule

// ===== rtl/real_3x3_matrix_inverse_top.sv =====
// Top level of the 3x3 matrix inverse: adjugate over determinant pipeline.
// Depends on minv_pkg, minv_if, minv_front and minv_div.
//
//   Channel   Direction  Handshake    Payload
//   req_chan  in         valid/ready  a00..a22, signed Q8.16 matrix entries
//   rsp_chan  out        valid/ready  r00..r22 inverse, singular, saturated
//
// One matrix may enter in every cycle while the result side is not stalled;
// the sustained rate is then one transfer per clock. A matrix passes four
// front stages for products, cofactors and determinant, then one setup
// stage, one overflow check stage, ENTRY_WIDTH + 1 quotient stages of the
// restoring divider (one bit each, set by the quotient width) and an output
// register.
// Reset is synchronous and clears only the stage valid bits.
// Each stage moves when it is empty or the stage after it moves, so a stall
// at the output fills the bubbles first and loses or repeats nothing.
module real_3x3_matrix_inverse_top #(
   parameter int unsigned FRAC_BITS   = 16,
   parameter int unsigned ENTRY_WIDTH = 24
) (
   input logic        clock,
   input logic        reset,
   minv_req_if.sink   req_chan,
   minv_rsp_if.source rsp_chan
);
   import minv_pkg::*;

   localparam int unsigned AW = 2 * ENTRY_WIDTH + 1;
   localparam int unsigned DW = 3 * ENTRY_WIDTH + 3;

   // Matrix entries in row-major order.
   logic signed [ENTRY_WIDTH-1:0] a [NUM_ENTRIES];
   assign a[0] = req_chan.a00;
   assign a[1] = req_chan.a01;
   assign a[2] = req_chan.a02;
   assign a[3] = req_chan.a10;
   assign a[4] = req_chan.a11;
   assign a[5] = req_chan.a12;
   assign a[6] = req_chan.a20;
   assign a[7] = req_chan.a21;
   assign a[8] = req_chan.a22;

   // Between the two halves travel the exact adjugate and determinant.
   logic                 mid_valid;
   logic                 mid_ready;
   logic signed [AW-1:0] adj [NUM_ENTRIES];
   logic signed [DW-1:0] det;

   logic signed [ENTRY_WIDTH-1:0] res [NUM_ENTRIES];
   minv_status_type               status;

   minv_front #(
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .a        (a),
      .out_valid(mid_valid),
      .out_ready(mid_ready),
      .adj      (adj),
      .det      (det)
   );

   // Each quotient is adj * 2^(2*FRAC_BITS) / det, truncated toward zero.
   minv_div #(
      .ENTRY_WIDTH(ENTRY_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (mid_valid),
      .in_ready (mid_ready),
      .adj      (adj),
      .det      (det),
      .out_valid(rsp_chan.valid),
      .out_ready(rsp_chan.ready),
      .res      (res),
      .status   (status)
   );

   assign rsp_chan.r00       = res[0];
   assign rsp_chan.r01       = res[1];
   assign rsp_chan.r02       = res[2];
   assign rsp_chan.r10       = res[3];
   assign rsp_chan.r11       = res[4];
   assign rsp_chan.r12       = res[5];
   assign rsp_chan.r20       = res[6];
   assign rsp_chan.r21       = res[7];
   assign rsp_chan.r22       = res[8];
   assign rsp_chan.singular  = status.singular;
   assign rsp_chan.saturated = status.saturated;

endmodule

// ===== rtl/minv_checker.sv =====
// Port-level assertions for the matrix inverse top level, and their bind.
// Depends on real_3x3_matrix_inverse_top.
module minv_checker #(
   parameter int unsigned ENTRY_WIDTH = 24
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_singular,
   input logic                     rsp_saturated,
   input logic [9*ENTRY_WIDTH-1:0] rsp_entries
);

   // A pending result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A singular matrix gives all-zero entries and no saturation.
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && (rsp_entries == '0))
      else $error("singular result with nonzero entries or saturation");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // With no result waiting, every stage can move and the input is ready.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while the output is empty");

endmodule

bind real_3x3_matrix_inverse_top minv_checker #(
   .ENTRY_WIDTH(ENTRY_WIDTH)
) u_minv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_singular (rsp_chan.singular),
   .rsp_saturated(rsp_chan.saturated),
   .rsp_entries  ({rsp_chan.r00, rsp_chan.r01, rsp_chan.r02,
                   rsp_chan.r10, rsp_chan.r11, rsp_chan.r12,
                   rsp_chan.r20, rsp_chan.r21, rsp_chan.r22})
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3x3 matrix inverse pipeline.
// Depends on minv_pkg, minv_if and real_3x3_matrix_inverse_top.
module testbench;
   import minv_pkg::*;

   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned ENTRY_WIDTH = 24;
   localparam int unsigned LATENCY     = ENTRY_WIDTH + 8;
   localparam int unsigned RANDOM_MATRICES = 1525;
   localparam int unsigned IDLE_LIMIT  = 20000;

   typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

   typedef struct {
      entry_t a [NUM_ENTRIES];
   } matrix_t;

   typedef struct {
      entry_t r [NUM_ENTRIES];
      logic   singular;
      logic   saturated;
   } inverse_t;

   logic clock;
   logic reset;

   minv_req_if #(.ENTRY_WIDTH(ENTRY_WIDTH)) req_chan ();
   minv_rsp_if #(.ENTRY_WIDTH(ENTRY_WIDTH)) rsp_chan ();

   real_3x3_matrix_inverse_top #(
      .FRAC_BITS(FRAC_BITS),
      .ENTRY_WIDTH(ENTRY_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Matrices waiting to be sent, and inverses waiting to come back.
   matrix_t  pending_matrices [$];
   inverse_t expected_inverses [$];
   int unsigned mismatch_count;
   bit stimulus_done;
   int unsigned idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      else if (roll < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // The inverse computed as the adjugate over the exact determinant. All
   // products fit easily in 128 bits: cofactors reach 2^47 and the scaled
   // numerator about 2^79, so signed 128-bit math is exact here.
   function automatic inverse_t invert_matrix(matrix_t m);
      inverse_t res;
      logic signed [127:0] e [NUM_ENTRIES];
      logic signed [127:0] cof [NUM_ENTRIES];
      logic signed [127:0] det, num, quot, pos_lim, neg_lim;
      res.singular  = 1'b0;
      res.saturated = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) e[i] = m.a[i];
      cof[0] = e[4]*e[8] - e[5]*e[7];
      cof[1] = e[2]*e[7] - e[1]*e[8];
      cof[2] = e[1]*e[5] - e[2]*e[4];
      cof[3] = e[5]*e[6] - e[3]*e[8];
      cof[4] = e[0]*e[8] - e[2]*e[6];
      cof[5] = e[2]*e[3] - e[0]*e[5];
      cof[6] = e[3]*e[7] - e[4]*e[6];
      cof[7] = e[1]*e[6] - e[0]*e[7];
      cof[8] = e[0]*e[4] - e[1]*e[3];
      det = e[0]*cof[0] + e[1]*cof[3] + e[2]*cof[6];
      pos_lim = (128'sd1 <<< (ENTRY_WIDTH-1)) - 1;
      neg_lim = -(128'sd1 <<< (ENTRY_WIDTH-1));
      if (det == 0) begin
         for (int i = 0; i < NUM_ENTRIES; i++) res.r[i] = '0;
         res.singular = 1'b1;
         return res;
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         num  = cof[i] <<< (2*FRAC_BITS);
         // SystemVerilog signed division truncates toward zero.
         quot = num / det;
         if (quot > pos_lim) begin
            quot = pos_lim;
            res.saturated = 1'b1;
         end else if (quot < neg_lim) begin
            quot = neg_lim;
            res.saturated = 1'b1;
         end
         res.r[i] = quot[ENTRY_WIDTH-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      mismatch_count++;
   endtask

   function automatic entry_t random_entry();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0: return entry_t'($urandom);
         1: return entry_t'($urandom_range(0, 8)) <<< FRAC_BITS;
         2: return -(entry_t'($urandom_range(0, 8)) <<< FRAC_BITS);
         3: return entry_t'(32'sd0 - $urandom_range(0, 255));
         4: return entry_t'($urandom_range(0, 255));
         default: return entry_t'($urandom_range(0, 32'h3_FFFF))
                         - entry_t'(32'h2_0000);
      endcase
   endfunction

   // Stimulus: directed corner matrices first, then mostly well-conditioned
   // random ones mixed with deliberately singular and extreme ones.
   initial begin
      matrix_t m;
      entry_t one, big, tiny;
      one  = entry_t'(1) <<< FRAC_BITS;
      big  = {1'b0, {(ENTRY_WIDTH-1){1'b1}}};
      tiny = {1'b1, {(ENTRY_WIDTH-1){1'b0}}};

      // Identity gives the identity back.
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? one : '0;
      pending_matrices.push_back(m);
      // All zeros is singular.
      foreach (m.a[i]) m.a[i] = '0;
      pending_matrices.push_back(m);
      // All three rows equal is singular though the entries are not zero.
      foreach (m.a[i]) m.a[i] = entry_t'(i % 3 + 1) <<< FRAC_BITS;
      pending_matrices.push_back(m);
      // Diagonal of the smallest positive step: the inverse overflows.
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? entry_t'(1) : '0;
      pending_matrices.push_back(m);
      // Diagonal of the most negative value, and of the largest value.
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? tiny : '0;
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? big : '0;
      pending_matrices.push_back(m);
      // Negated identity, and a permutation matrix.
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? -one : '0;
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i == 1 || i == 5 || i == 6) ? one : '0;
      pending_matrices.push_back(m);
      // Every entry at an extreme, first all positive, then both signs mixed.
      foreach (m.a[i]) m.a[i] = big;
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i % 2 == 0) ? big : tiny;
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? tiny : big;
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? big : tiny;
      pending_matrices.push_back(m);
      // Half scale on the diagonal: exact inverse of two.
      foreach (m.a[i]) m.a[i] = (i % 4 == 0) ? (one >>> 1) : '0;
      pending_matrices.push_back(m);
      // Alternating bit patterns so every input bit toggles.
      foreach (m.a[i]) m.a[i] = (i % 2 == 0) ? entry_t'(24'h555555) : entry_t'(24'hAAAAAA);
      pending_matrices.push_back(m);
      foreach (m.a[i]) m.a[i] = (i % 2 == 0) ? entry_t'(24'hAAAAAA) : entry_t'(24'h555555);
      pending_matrices.push_back(m);

      for (int n = 0; n < RANDOM_MATRICES; n++) begin
         int unsigned kind;
         kind = $urandom_range(0, 99);
         foreach (m.a[i]) m.a[i] = random_entry();
         if (kind < 10) begin
            // Copy one row onto another so the determinant vanishes.
            int unsigned src, dst;
            src = $urandom_range(0, 2);
            dst = (src + $urandom_range(1, 2)) % 3;
            for (int c = 0; c < 3; c++) m.a[dst*3+c] = m.a[src*3+c];
         end else if (kind < 15) begin
            foreach (m.a[i]) m.a[i] = entry_t'($urandom);
         end
         pending_matrices.push_back(m);
      end
      stimulus_done = 1'b1;
   end

   // Driver: drops valid over gaps of random length and retires a matrix on
   // each accepted transfer, predicting its inverse at that moment.
   int unsigned send_gap;
   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      rsp_chan.ready = 1'b0;
      {req_chan.a00, req_chan.a01, req_chan.a02} = '0;
      {req_chan.a10, req_chan.a11, req_chan.a12} = '0;
      {req_chan.a20, req_chan.a21, req_chan.a22} = '0;
      mismatch_count = 0;
      send_gap = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            matrix_t sent;
            sent = pending_matrices.pop_front();
            expected_inverses.push_back(invert_matrix(sent));
            send_gap = pick_gap();
         end
         // Decide the next state of valid once per edge.
         if ((!req_chan.valid || req_chan.ready) ) begin
            if (send_gap == 0 && pending_matrices.size() > 0) begin
               matrix_t nxt;
               nxt = pending_matrices[0];
               req_chan.valid <= 1'b1;
               req_chan.a00 <= nxt.a[0]; req_chan.a01 <= nxt.a[1];
               req_chan.a02 <= nxt.a[2]; req_chan.a10 <= nxt.a[3];
               req_chan.a11 <= nxt.a[4]; req_chan.a12 <= nxt.a[5];
               req_chan.a20 <= nxt.a[6]; req_chan.a21 <= nxt.a[7];
               req_chan.a22 <= nxt.a[8];
            end else begin
               req_chan.valid <= 1'b0;
               if (send_gap > 0) send_gap = send_gap - 1;
            end
         end
      end
   end

   // Monitor: compares each accepted inverse with the oldest prediction,
   // and stalls the result side at random.
   int unsigned stall_gap;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            inverse_t got, want;
            got.r = '{rsp_chan.r00, rsp_chan.r01, rsp_chan.r02,
                      rsp_chan.r10, rsp_chan.r11, rsp_chan.r12,
                      rsp_chan.r20, rsp_chan.r21, rsp_chan.r22};
            got.singular  = rsp_chan.singular;
            got.saturated = rsp_chan.saturated;
            if (expected_inverses.size() == 0) begin
               report_mismatch("unexpected inverse", 0, 0);
            end else begin
               want = expected_inverses.pop_front();
               for (int i = 0; i < NUM_ENTRIES; i++)
                  if (got.r[i] !== want.r[i])
                     report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                     got.r[i], want.r[i]);
               if (got.singular !== want.singular)
                  report_mismatch("singular", got.singular, want.singular);
               if (got.saturated !== want.saturated)
                  report_mismatch("saturated", got.saturated, want.saturated);
            end
            stall_gap = pick_gap();
         end
         if (stall_gap > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_gap = stall_gap - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready)
          || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The end of the run: everything sent and returned, then a short drain so
   // that any spurious extra inverse is still caught.
   initial begin
      idle_cycles = 0;
      stall_gap = 0;
      fork
         begin
            wait (stimulus_done);
            while (pending_matrices.size() > 0 || expected_inverses.size() > 0)
               @(posedge clock);
            repeat (LATENCY + 8) @(posedge clock);
            if (mismatch_count == 0) begin
               $display("end of test: clean");
            end else begin
               $display("end of test: mismatches");
            end
         end
         begin
            wait (idle_cycles >= IDLE_LIMIT);
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
         end
      join_any
      $finish;
   end

endmodule
